>>> rtl/ecal_pkg.sv
// Shared constants, types and the cumulative-days table for the epoch-to-calendar pipeline.
`default_nettype none
package ecal_pkg;

  // Pipeline depth: day split 3 stages, time-of-day and date branches 6 stages each
  localparam int unsigned NSTG = 9;
  localparam int unsigned SPLIT_STG = 3;

  typedef logic [NSTG-1:0] stage_en_t;

  localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
  localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
  localparam logic [5:0]  SECS_PER_MIN  = 6'd60;
  localparam logic [10:0] DAYS_PER_QUAD = 11'd1461;

  // Reciprocals: floor(2^k / d), each followed by a single correction step
  localparam logic [22:0] RECIP_675  = 23'd6362914; // k = 32, seconds >> 7 over 675
  localparam logic [5:0]  RECIP_3600 = 6'd36;       // k = 17
  localparam logic [6:0]  RECIP_60   = 7'd68;       // k = 12
  localparam logic [5:0]  RECIP_1461 = 6'd44;       // k = 16
  localparam logic [13:0] RECIP_7    = 14'd9362;    // k = 16

  // Days from 1968-01-01 to 1970-01-01; 1970-01-01 was a Thursday
  localparam logic [15:0] DAYS_1968_TO_1970 = 16'd731;
  localparam logic [15:0] WEEKDAY_OFFSET    = 16'd4;

  // First day of month idx (0 = January) within the year
  function automatic logic [8:0] cum_days(input logic leap, input logic [3:0] idx);
    logic [8:0] d;
    unique case (idx)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd59;
      4'd3:    d = 9'd90;
      4'd4:    d = 9'd120;
      4'd5:    d = 9'd151;
      4'd6:    d = 9'd181;
      4'd7:    d = 9'd212;
      4'd8:    d = 9'd243;
      4'd9:    d = 9'd273;
      4'd10:   d = 9'd304;
      4'd11:   d = 9'd334;
      default: d = 9'd0;
    endcase
    if (leap && (idx >= 4'd2)) begin
      d = d + 9'd1;
    end
    return d;
  endfunction

endpackage
`default_nettype wire

>>> rtl/ecal_day_split.sv
// Split of the second count into whole days and seconds of the day, three stages.
`default_nettype none
module ecal_day_split (
  input  wire logic              clk,
  input  wire ecal_pkg::stage_en_t en,
  input  wire logic [31:0]       epoch_seconds,
  output logic      [15:0]       days,
  output logic      [16:0]       secs_of_day
);
  import ecal_pkg::*;

  logic [47:0] prod1;
  logic [15:0] q1;
  logic [31:0] secs1;
  logic [32:0] qm2;
  logic [31:0] diff2;
  logic [15:0] q2;
  logic [17:0] r2;
  logic [17:0] r2_adj;

  assign prod1  = 48'(epoch_seconds[31:7]) * 48'(RECIP_675);
  assign qm2    = 33'(q1) * 33'(SECS_PER_DAY);
  assign diff2  = secs1 - qm2[31:0];
  assign r2_adj = r2 - 18'(SECS_PER_DAY);

  // Estimate the day count, never more than one short
  always_ff @(posedge clk) begin
    if (en[0]) begin
      q1    <= prod1[47:32];
      secs1 <= epoch_seconds;
    end
  end

  // Form the remainder against the estimate
  always_ff @(posedge clk) begin
    if (en[1]) begin
      q2 <= q1;
      r2 <= diff2[17:0];
    end
  end

  // Correct a short estimate
  always_ff @(posedge clk) begin
    if (en[2]) begin
      if (r2 >= 18'(SECS_PER_DAY)) begin
        days        <= q2 + 16'd1;
        secs_of_day <= r2_adj[16:0];
      end else begin
        days        <= q2;
        secs_of_day <= r2[16:0];
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/ecal_tod.sv
// Time-of-day branch: hour, minute and second from the seconds of the day, six stages.
`default_nettype none
module ecal_tod (
  input  wire logic              clk,
  input  wire ecal_pkg::stage_en_t en,
  input  wire logic [16:0]       secs_of_day,
  output logic      [4:0]        hour,
  output logic      [5:0]        minute,
  output logic      [5:0]        second
);
  import ecal_pkg::*;

  logic [22:0] hprod;
  logic [16:0] rem4;
  logic [4:0]  h4;
  logic [16:0] hsecs5;
  logic [16:0] msdiff5;
  logic [4:0]  h5;
  logic [12:0] ms5;
  logic [12:0] ms5_adj;
  logic [4:0]  h6;
  logic [11:0] ms6;
  logic [18:0] mprod;
  logic [11:0] ms7;
  logic [5:0]  m7;
  logic [4:0]  h7;
  logic [11:0] msecs8;
  logic [11:0] sdiff8;
  logic [5:0]  m8;
  logic [6:0]  sr8;
  logic [4:0]  h8;
  logic [6:0]  sr8_adj;

  assign hprod   = 23'(secs_of_day) * 23'(RECIP_3600);
  assign hsecs5  = 17'(h4) * 17'(SECS_PER_HOUR);
  assign msdiff5 = rem4 - hsecs5;
  assign ms5_adj = ms5 - 13'(SECS_PER_HOUR);
  assign mprod   = 19'(ms6) * 19'(RECIP_60);
  assign msecs8  = 12'(m7) * 12'(SECS_PER_MIN);
  assign sdiff8  = ms7 - msecs8;
  assign sr8_adj = sr8 - 7'(SECS_PER_MIN);

  always_ff @(posedge clk) begin
    if (en[3]) begin
      h4   <= hprod[21:17];
      rem4 <= secs_of_day;
    end
    if (en[4]) begin
      h5  <= h4;
      ms5 <= msdiff5[12:0];
    end
    if (en[5]) begin
      if (ms5 >= 13'(SECS_PER_HOUR)) begin
        h6  <= h5 + 5'd1;
        ms6 <= ms5_adj[11:0];
      end else begin
        h6  <= h5;
        ms6 <= ms5[11:0];
      end
    end
    if (en[6]) begin
      m7  <= mprod[17:12];
      ms7 <= ms6;
      h7  <= h6;
    end
    if (en[7]) begin
      m8  <= m7;
      sr8 <= sdiff8[6:0];
      h8  <= h7;
    end
    if (en[8]) begin
      hour <= h8;
      if (sr8 >= 7'(SECS_PER_MIN)) begin
        minute <= m8 + 6'd1;
        second <= sr8_adj[5:0];
      end else begin
        minute <= m8;
        second <= sr8[5:0];
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/ecal_date.sv
// Date branch: year, month, day of month and weekday from the day count, six stages.
`default_nettype none
module ecal_date (
  input  wire logic              clk,
  input  wire ecal_pkg::stage_en_t en,
  input  wire logic [15:0]       days,
  output logic signed [7:0]      year_from_2000,
  output logic      [3:0]        month,
  output logic      [4:0]        day_of_month,
  output logic      [2:0]        weekday
);
  import ecal_pkg::*;

  logic [15:0] d68;
  logic [15:0] wsum;
  logic [21:0] cprod;
  logic [29:0] wprod;
  logic [15:0] d4;
  logic [15:0] wsum4;
  logic [5:0]  c4;
  logic [12:0] w4;
  logic [16:0] cdays5;
  logic [15:0] ddiff5;
  logic [15:0] wmul5;
  logic [15:0] wdiff5;
  logic [5:0]  c5;
  logic [11:0] dr5;
  logic [3:0]  wr5;
  logic [11:0] dr5_adj;
  logic [3:0]  wr5_adj;
  logic [5:0]  c6;
  logic [10:0] dr6;
  logic [2:0]  wd6;
  logic [1:0]  yi;
  logic [10:0] doy_full;
  logic        leap_c;
  logic [7:0]  yr7;
  logic [8:0]  doy7;
  logic        leap7;
  logic [2:0]  wd7;
  logic [3:0]  mi_c;
  logic [3:0]  mi8;
  logic [8:0]  doy8;
  logic        leap8;
  logic [7:0]  yr8;
  logic [2:0]  wd8;
  logic [8:0]  dom9;

  assign d68     = days + DAYS_1968_TO_1970;
  assign wsum    = days + WEEKDAY_OFFSET;
  assign cprod   = 22'(d68) * 22'(RECIP_1461);
  assign wprod   = 30'(wsum) * 30'(RECIP_7);
  assign cdays5  = 17'(c4) * 17'(DAYS_PER_QUAD);
  assign ddiff5  = d4 - cdays5[15:0];
  assign wmul5   = 16'(w4) * 16'd7;
  assign wdiff5  = wsum4 - wmul5;
  assign dr5_adj = dr5 - 12'(DAYS_PER_QUAD);
  assign wr5_adj = wr5 - 4'd7;

  // Year within the four-year block; the first year of each block is a leap year
  always_comb begin
    if (dr6 < 11'd366) begin
      yi       = 2'd0;
      doy_full = dr6;
      leap_c   = 1'b1;
    end else if (dr6 < 11'd731) begin
      yi       = 2'd1;
      doy_full = dr6 - 11'd366;
      leap_c   = 1'b0;
    end else if (dr6 < 11'd1096) begin
      yi       = 2'd2;
      doy_full = dr6 - 11'd731;
      leap_c   = 1'b0;
    end else begin
      yi       = 2'd3;
      doy_full = dr6 - 11'd1096;
      leap_c   = 1'b0;
    end
  end

  // Last month whose first day is not after the day of the year
  always_comb begin
    mi_c = 4'd0;
    for (int m = 1; m < 12; m++) begin
      if (doy7 >= cum_days(leap7, 4'(m))) begin
        mi_c = 4'(m);
      end
    end
  end

  assign dom9 = doy8 - cum_days(leap8, mi8) + 9'd1;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      d4    <= d68;
      wsum4 <= wsum;
      c4    <= cprod[21:16];
      w4    <= wprod[28:16];
    end
    if (en[4]) begin
      c5  <= c4;
      dr5 <= ddiff5[11:0];
      wr5 <= wdiff5[3:0];
    end
    if (en[5]) begin
      if (dr5 >= 12'(DAYS_PER_QUAD)) begin
        c6  <= c5 + 6'd1;
        dr6 <= dr5_adj[10:0];
      end else begin
        c6  <= c5;
        dr6 <= dr5[10:0];
      end
      wd6 <= (wr5 >= 4'd7) ? wr5_adj[2:0] : wr5[2:0];
    end
    if (en[6]) begin
      // 1968 + 4 blocks + year in block, less 2000
      yr7   <= {c6, yi} - 8'd32;
      doy7  <= doy_full[8:0];
      leap7 <= leap_c;
      wd7   <= wd6;
    end
    if (en[7]) begin
      mi8   <= mi_c;
      doy8  <= doy7;
      leap8 <= leap7;
      yr8   <= yr7;
      wd8   <= wd7;
    end
    if (en[8]) begin
      year_from_2000 <= yr8;
      month          <= mi8 + 4'd1;
      day_of_month   <= dom9[4:0];
      weekday        <= wd8;
    end
  end

endmodule
`default_nettype wire

>>> rtl/epoch_seconds_to_calendar.sv
// Top level of the epoch-seconds to calendar-date converter: stage control and wiring.
//
// Converts an unsigned 32-bit count of seconds since 1970-01-01 00:00:00 into
// year (offset from 2000, signed), month, day of month, weekday (0 = Sunday),
// hour, minute and second. Every year divisible by four counts as a leap year,
// so dates from March 2100 on carry a one-day shift.
//
// Input channel: epoch_seconds with in_valid / in_ready. Output channel: the
// seven date fields with out_valid / out_ready. An item moves on each edge at
// which valid and ready are both high.
//
// Nine register stages; one item is taken every cycle while the output is
// drained. The depth comes from the chain of reciprocal multiply, remainder
// and one-step correction for each division (by 86400, 1461, 3600, 60 and 7),
// each on its own register stage.
//
// When the receiver stalls, the pipeline closes up its bubbles and then holds;
// in_ready drops only once every stage holds an item. Reset empties the stages.
`default_nettype none
module epoch_seconds_to_calendar (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [31:0]       epoch_seconds,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic signed [7:0]      year_from_2000,
  output logic      [3:0]        month,
  output logic      [4:0]        day_of_month,
  output logic      [2:0]        weekday,
  output logic      [4:0]        hour,
  output logic      [5:0]        minute,
  output logic      [5:0]        second
);
  import ecal_pkg::*;

  logic [NSTG-1:0] valid;
  stage_en_t       en;
  logic [15:0]     days;
  logic [16:0]     secs_of_day;

  // A stage loads when it is empty or when the stage after it loads too
  always_comb begin
    en[NSTG-1] = !valid[NSTG-1] || out_ready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      en[k] = !valid[k] || en[k+1];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = valid[NSTG-1];

  // Advance the valid bits alongside the data
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (en[0]) begin
        valid[0] <= in_valid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (en[k]) begin
          valid[k] <= valid[k-1];
        end
      end
    end
  end

  ecal_day_split u_split (
    .clk           (clk),
    .en            (en),
    .epoch_seconds (epoch_seconds),
    .days          (days),
    .secs_of_day   (secs_of_day)
  );

  ecal_tod u_tod (
    .clk         (clk),
    .en          (en),
    .secs_of_day (secs_of_day),
    .hour        (hour),
    .minute      (minute),
    .second      (second)
  );

  ecal_date u_date (
    .clk            (clk),
    .en             (en),
    .days           (days),
    .year_from_2000 (year_from_2000),
    .month          (month),
    .day_of_month   (day_of_month),
    .weekday        (weekday)
  );

endmodule
`default_nettype wire
